// File: design/apfp_pkg.sv
// Shared types and constants for the addressed packet frame parser.
package apfp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h5E;
    localparam logic [7:0] ABORT_BYTE = 8'h0B;
    localparam logic [7:0] OWN_ADDRESS_RESET = 8'd69;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_HEADER_OK   = 3'd1,
        EV_PACKET_OK   = 3'd2,
        EV_HEADER_BAD  = 3'd3,
        EV_PAYLOAD_BAD = 3'd4,
        EV_TOO_LONG    = 3'd5
    } event_t;

    typedef enum logic [7:0] {
        ST_SYNC1     = 8'b0000_0001,
        ST_SYNC2     = 8'b0000_0010,
        ST_ADDRESS   = 8'b0000_0100,
        ST_FLAGS     = 8'b0000_1000,
        ST_HDR_CHECK = 8'b0001_0000,
        ST_LENGTH    = 8'b0010_0000,
        ST_PAYLOAD   = 8'b0100_0000,
        ST_PAY_CHECK = 8'b1000_0000
    } parse_state_t;

    typedef struct packed {
        event_t     event_res;
        logic       echo_valid;
        logic       payload_valid;
        logic [4:0] payload_index;
        logic [7:0] payload_byte;
        logic       for_me;
        logic [7:0] frame_address;
        logic [7:0] frame_flags;
    } result_t;

endpackage

// File: design/apfp_parser.sv
// Frame state machine: holds the parse state and computes the result of each byte.
module apfp_parser
    import apfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic [7:0] own_address,
    output result_t    res
);

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    parse_state_t state_reg, state_next;
    logic [7:0] address_reg, address_next;
    logic [7:0] flags_reg, flags_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] xor_reg, xor_next;
    logic       mine;

    always_comb
    begin
        state_next   = state_reg;
        address_next = address_reg;
        flags_next   = flags_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        xor_next     = xor_reg;
        mine         = (address_reg == own_address);

        res               = '0;
        res.event_res     = EV_NONE;

        if (rx_byte == ABORT_BYTE)
        begin
            state_next = ST_SYNC1;
        end
        else
        begin
            unique case (state_reg)
                ST_SYNC1:
                begin
                    if (rx_byte == SYNC_BYTE)
                    begin
                        state_next = ST_SYNC2;
                    end
                end
                ST_SYNC2:
                begin
                    if (rx_byte == SYNC_BYTE)
                    begin
                        state_next = ST_ADDRESS;
                    end
                end
                ST_ADDRESS:
                begin
                    address_next = rx_byte;
                    state_next   = ST_FLAGS;
                end
                ST_FLAGS:
                begin
                    flags_next = rx_byte;
                    state_next = ST_HDR_CHECK;
                end
                ST_HDR_CHECK:
                begin
                    state_next = ST_LENGTH;
                    if (mine)
                    begin
                        if (rx_byte == (address_reg ^ flags_reg))
                        begin
                            res.event_res  = EV_HEADER_OK;
                            res.echo_valid = 1'b1;
                        end
                        else
                        begin
                            res.event_res = EV_HEADER_BAD;
                            state_next    = ST_SYNC1;
                        end
                    end
                end
                ST_LENGTH:
                begin
                    length_next = rx_byte;
                    seen_next   = '0;
                    xor_next    = rx_byte;
                    if (rx_byte > MaxLen)
                    begin
                        res.event_res = EV_TOO_LONG;
                        state_next    = ST_SYNC1;
                    end
                    else if (rx_byte == 8'd0)
                    begin
                        state_next = ST_PAY_CHECK;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD:
                begin
                    res.payload_valid = 1'b1;
                    res.payload_index = seen_reg[4:0];
                    res.payload_byte  = rx_byte;
                    xor_next          = xor_reg ^ rx_byte;
                    seen_next         = seen_reg + 8'd1;
                    if (seen_next == length_reg)
                    begin
                        state_next = ST_PAY_CHECK;
                    end
                end
                ST_PAY_CHECK:
                begin
                    if (mine)
                    begin
                        if (rx_byte == xor_reg)
                        begin
                            res.event_res  = EV_PACKET_OK;
                            res.echo_valid = 1'b1;
                        end
                        else
                        begin
                            res.event_res = EV_PAYLOAD_BAD;
                        end
                    end
                    state_next = ST_SYNC1;
                end
                default:
                begin
                    state_next = ST_SYNC1;
                end
            endcase
        end

        res.for_me        = (address_next == own_address);
        res.frame_address = address_next;
        res.frame_flags   = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SYNC1;
            address_reg <= '0;
            flags_reg   <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
            xor_reg     <= '0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            address_reg <= address_next;
            flags_reg   <= flags_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
        end
    end

endmodule

// File: design/apfp_result_reg.sv
// Output register holding one result item until the receiver takes it.
module apfp_result_reg
    import apfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    taken,
    output logic    valid,
    output result_t res_out
);

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// File: design/addressed_packet_frame_parser.sv
// Top level of the addressed packet frame parser.
// Takes one received byte per item and returns one result item per byte. Items are
// registered and appear in the cycle after their byte is taken, one item per cycle;
// the single output register sets that rate, and a new item is taken whenever that
// register is empty or is being emptied in the same cycle. Frames start with two '^'
// bytes, 0x0B aborts any frame, and header/payload checks apply only to own_address.
module addressed_packet_frame_parser
    import apfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic       echo_valid,
    output logic       payload_valid,
    output logic [4:0] payload_index,
    output logic [7:0] payload_byte,
    output logic       for_me,
    output logic [7:0] frame_address,
    output logic [7:0] frame_flags
);

    logic [7:0] own_address_reg;
    logic       accept;
    result_t    step_res;
    result_t    out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= OWN_ADDRESS_RESET;
        end
        else if (cfg_wr_en)
        begin
            own_address_reg <= cfg_wr_data;
        end
    end

    assign in_stall = out_valid && out_stall;
    assign accept   = in_valid && !in_stall;

    apfp_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .own_address(own_address_reg),
        .res        (step_res)
    );

    apfp_result_reg u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .res_in (step_res),
        .taken  (!out_stall),
        .valid  (out_valid),
        .res_out(out_res)
    );

    assign event_res     = out_res.event_res;
    assign echo_valid    = out_res.echo_valid;
    assign payload_valid = out_res.payload_valid;
    assign payload_index = out_res.payload_index;
    assign payload_byte  = out_res.payload_byte;
    assign for_me        = out_res.for_me;
    assign frame_address = out_res.frame_address;
    assign frame_flags   = out_res.frame_flags;

endmodule
